>>> src/mmhq_pkg.sv
// mmhq_pkg: request kinds, response codes and the control and view
// structs shared by the cell row of the min-max queue
// no dependencies
package mmhq_pkg;

   localparam int KEY_W   = 32;
   localparam int TOTAL_W = 11;

   // request kinds on req_tuser; code 7 means no operation
   typedef enum logic [2:0] {
      REQ_INSERT      = 3'd0,
      REQ_EXTRACT_MIN = 3'd1,
      REQ_PEEK_MIN    = 3'd2,
      REQ_EXTRACT_MAX = 3'd3,
      REQ_PEEK_MAX    = 3'd4,
      REQ_SIZE        = 3'd5,
      REQ_CLEAR       = 3'd6
   } req_kind_type;

   // response status codes
   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL  = 2'd2;

   // what one row of cells does in a cycle
   typedef enum logic [2:0] {
      OP_HOLD,
      OP_INSERT,
      OP_POP_FRONT,
      OP_DROP_LAST,
      OP_CLEAR
   } chain_op_type;

   // command broadcast to every cell of a row
   typedef struct packed {
      chain_op_type      op;
      logic [KEY_W-1:0]  key;
   } chain_cmd_type;

   // contents of one cell as seen by its neighbours
   typedef struct packed {
      logic              valid;
      logic [KEY_W-1:0]  key;
   } cell_view_type;

endpackage

>>> src/mmhq_cell.sv
// mmhq_cell: one storage cell of a sorted row, holding a key and a valid bit
// depends on mmhq_pkg for the command and view structs
module mmhq_cell
   import mmhq_pkg::*;
#(
   parameter bit ASCENDING = 1'b1,
   parameter bit FIRST     = 1'b0
) (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   input  cell_view_type left_view,
   input  cell_view_type right_view,
   output cell_view_type own_view
);

   logic             valid_ff, valid_in;
   logic [KEY_W-1:0] key_ff, key_in;
   logic             own_keeps, left_keeps;

   // a cell keeps its key on insert when it is already in order before the new key
   always_comb begin
      if (ASCENDING) begin
         own_keeps  = valid_ff && ($signed(key_ff) <= $signed(cmd.key));
         left_keeps = left_view.valid && ($signed(left_view.key) <= $signed(cmd.key));
      end else begin
         own_keeps  = valid_ff && ($signed(key_ff) >= $signed(cmd.key));
         left_keeps = left_view.valid && ($signed(left_view.key) >= $signed(cmd.key));
      end
   end

   // next contents from own state, neighbours and the row command
   always_comb begin
      key_in   = key_ff;
      valid_in = valid_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!own_keeps) begin
               if (!FIRST && !left_keeps) begin
                  key_in = left_view.key;
               end else begin
                  key_in = cmd.key;
               end
            end
            valid_in = valid_ff | (FIRST ? 1'b1 : left_view.valid);
         end
         OP_POP_FRONT: begin
            key_in   = right_view.key;
            valid_in = right_view.valid;
         end
         OP_DROP_LAST: begin
            valid_in = valid_ff & right_view.valid;
         end
         OP_CLEAR: begin
            valid_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   // valid bit is control, key is payload
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff <= key_in;
   end

   assign own_view = '{valid: valid_ff, key: key_ff};

endmodule

>>> src/mmhq_chain.sv
// mmhq_chain: a row of DEPTH cells kept sorted, best key at the head
// depends on mmhq_pkg and mmhq_cell
module mmhq_chain
   import mmhq_pkg::*;
#(
   parameter int DEPTH     = 1024,
   parameter bit ASCENDING = 1'b1
) (
   input  logic          clock,
   input  logic          reset,
   input  chain_cmd_type cmd,
   output cell_view_type head_view
);

   cell_view_type views [DEPTH];

   // each cell sees its left and right neighbour; the ends see an empty cell
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      cell_view_type left_v, right_v;

      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = views[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = views[i+1];
      end

      mmhq_cell #(
         .ASCENDING (ASCENDING),
         .FIRST     (i == 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .left_view  (left_v),
         .right_view (right_v),
         .own_view   (views[i])
      );
   end

   assign head_view = views[0];

endmodule

>>> src/min_max_heap_queue.sv
// min_max_heap_queue: double-ended priority queue, top level
// depends on mmhq_pkg and mmhq_chain
//
// Takes one request per clock cycle while the response side keeps up and
// answers each one with exactly one response, registered in the cycle
// after it is taken; a waiting response does not block the next request as
// long as it is taken in the same cycle. The keys are held twice, in two
// rows of HEAP_DEPTH cells: one row sorted smallest first, the other
// largest first, so the minimum and the maximum always sit in a fixed head
// cell. An insert ripples into both rows at once; an extract shifts the row
// whose head is taken and retires the tail cell of the other row. Insert
// into a full queue is dropped with status 2, extract or peek on an empty
// queue answers status 1, and clear empties both rows at once. Responses
// carry the entry count after the request, taken modulo 2048.
module min_max_heap_queue
   import mmhq_pkg::*;
#(
   parameter int HEAP_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic [2:0]  req_tuser,   // [2:0] req_type
   // response channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [31:0] result_value, [42:32] entry_total, zero pad
   output logic [1:0]  rsp_tuser    // [1:0] status
);

   localparam int CNT_W = $clog2(HEAP_DEPTH + 1);

   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [KEY_W-1:0]   result_ff, result_in;
   logic [TOTAL_W-1:0] total_ff;
   logic [CNT_W+TOTAL_W-1:0] count_ext;

   logic          req_accept;
   logic          is_empty, is_full;
   req_kind_type  kind;
   chain_cmd_type asc_cmd, desc_cmd;
   cell_view_type min_view, max_view;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign kind       = req_kind_type'(req_tuser);
   assign is_empty   = (count_ff == '0);
   assign is_full    = (count_ff == CNT_W'(HEAP_DEPTH));

   // decode the request into row commands, the new count and the response
   always_comb begin
      asc_cmd   = '{op: OP_HOLD, key: req_tdata};
      desc_cmd  = '{op: OP_HOLD, key: req_tdata};
      count_in  = count_ff;
      status_in = ST_OK;
      result_in = '0;
      unique case (kind)
         REQ_INSERT: begin
            if (is_full) begin
               status_in = ST_FULL;
            end else begin
               asc_cmd.op  = OP_INSERT;
               desc_cmd.op = OP_INSERT;
               count_in    = count_ff + CNT_W'(1);
            end
         end
         REQ_EXTRACT_MIN: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               asc_cmd.op  = OP_POP_FRONT;
               desc_cmd.op = OP_DROP_LAST;
               count_in    = count_ff - CNT_W'(1);
               result_in   = min_view.key;
            end
         end
         REQ_PEEK_MIN: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               result_in = min_view.key;
            end
         end
         REQ_EXTRACT_MAX: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               desc_cmd.op = OP_POP_FRONT;
               asc_cmd.op  = OP_DROP_LAST;
               count_in    = count_ff - CNT_W'(1);
               result_in   = max_view.key;
            end
         end
         REQ_PEEK_MAX: begin
            if (is_empty) begin
               status_in = ST_EMPTY;
            end else begin
               result_in = max_view.key;
            end
         end
         REQ_CLEAR: begin
            asc_cmd.op  = OP_CLEAR;
            desc_cmd.op = OP_CLEAR;
            count_in    = '0;
         end
         default: begin
         end
      endcase
      // rows only move on a taken request
      if (!req_accept) begin
         asc_cmd.op  = OP_HOLD;
         desc_cmd.op = OP_HOLD;
         count_in    = count_ff;
      end
   end

   // smallest-first and largest-first rows
   mmhq_chain #(
      .DEPTH     (HEAP_DEPTH),
      .ASCENDING (1'b1)
   ) u_min_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (asc_cmd),
      .head_view (min_view)
   );

   mmhq_chain #(
      .DEPTH     (HEAP_DEPTH),
      .ASCENDING (1'b0)
   ) u_max_row (
      .clock     (clock),
      .reset     (reset),
      .cmd       (desc_cmd),
      .head_view (max_view)
   );

   // response valid follows the output handshake
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // count reported modulo the field width
   assign count_ext = {{TOTAL_W{1'b0}}, count_in};

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         status_ff <= status_in;
         result_ff <= result_in;
         total_ff  <= count_ext[TOTAL_W-1:0];
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'b0, total_ff, result_ff};
   assign rsp_tuser  = status_ff;

endmodule

>>> tb/tb.sv
// tb: self-checking testbench for the min_max_heap_queue double-ended priority queue
// depends on mmhq_pkg and min_max_heap_queue; a scoreboard class predicts every response
`timescale 1ns / 1ps

import mmhq_pkg::*;

typedef logic signed [31:0] key_type;

// predicted response for one request
typedef struct {
   logic [1:0]  status;
   key_type     key;
   logic [10:0] total;
} answer_type;

// keeps the queue contents as a sorted list and the responses still owed
class heap_scoreboard;
   int         depth;
   key_type    sorted_keys[$];
   answer_type owed[$];
   int         errors;
   int         requests;
   int         responses;
   int         peak;
   int         full_drops;
   int         empty_hits;

   function new(int depth_i);
      depth = depth_i;
   endfunction

   function int fill();
      return sorted_keys.size();
   endfunction

   function int pending();
      return owed.size();
   endfunction

   // work out the response to an accepted request
   function void note_request(logic [2:0] kind, logic [31:0] data);
      answer_type a;
      key_type    key;
      int         pos;
      a.status = ST_OK;
      a.key = '0;
      key = data;
      requests++;
      case (kind)
         REQ_INSERT: begin
            if (sorted_keys.size() >= depth) begin
               a.status = ST_FULL;
               full_drops++;
            end else begin
               pos = 0;
               while (pos < sorted_keys.size() && sorted_keys[pos] <= key) pos++;
               sorted_keys.insert(pos, key);
            end
         end
         REQ_EXTRACT_MIN, REQ_PEEK_MIN, REQ_EXTRACT_MAX, REQ_PEEK_MAX: begin
            if (sorted_keys.size() == 0) begin
               a.status = ST_EMPTY;
               empty_hits++;
            end else begin
               case (kind)
                  REQ_EXTRACT_MIN: a.key = sorted_keys.pop_front();
                  REQ_PEEK_MIN:    a.key = sorted_keys[0];
                  REQ_EXTRACT_MAX: a.key = sorted_keys.pop_back();
                  default:         a.key = sorted_keys[sorted_keys.size() - 1];
               endcase
            end
         end
         REQ_CLEAR: sorted_keys.delete();
         default: ;
      endcase
      a.total = 11'(sorted_keys.size());
      if (sorted_keys.size() > peak) peak = sorted_keys.size();
      owed.push_back(a);
   endfunction

   // compare one accepted response with the oldest prediction
   function void check_response(logic [1:0] status, logic [31:0] key, logic [10:0] total);
      answer_type a;
      responses++;
      if (owed.size() == 0) begin
         $error("response with no request outstanding: status %0d value %0d total %0d",
                status, $signed(key), total);
         errors++;
         return;
      end
      a = owed.pop_front();
      if (status !== a.status) begin
         $error("status: expected %0d, got %0d", a.status, status);
         errors++;
      end
      if (key !== a.key) begin
         $error("result_value: expected %0d, got %0d", a.key, $signed(key));
         errors++;
      end
      if (total !== a.total) begin
         $error("entry_total: expected %0d, got %0d", a.total, total);
         errors++;
      end
   endfunction
endclass

module tb;
   localparam int HEAP_DEPTH  = 1024;
   localparam int CYCLE_LIMIT = 400000;
   localparam logic [2:0] REQ_NOP = 3'd7;   // unused code, no operation

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;
   logic [2:0]  req_tuser = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   logic [1:0]  rsp_tuser;

   heap_scoreboard sb;
   bit             steady = 1'b0;
   int             cycle_count = 0;

   min_max_heap_queue #(.HEAP_DEPTH(HEAP_DEPTH)) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // idle cycles before the next request or response, none in steady stretches
   function int draw_wait();
      if (steady || $urandom_range(0, 3) == 0) return 0;
      return $urandom_range(0, 10);
   endfunction

   // keys: full range, a narrow band for duplicates, and the extremes
   function logic [31:0] rand_key();
      case ($urandom_range(0, 3))
         0, 1: return $urandom;
         2:    return 32'($signed($urandom_range(0, 15)) - 8);
         default: return $urandom_range(0, 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      endcase
   endfunction

   function logic [2:0] pick_kind();
      int r;
      r = $urandom_range(0, 99);
      if (r < 42) return REQ_INSERT;
      if (r < 54) return REQ_EXTRACT_MIN;
      if (r < 66) return REQ_EXTRACT_MAX;
      if (r < 75) return REQ_PEEK_MIN;
      if (r < 84) return REQ_PEEK_MAX;
      if (r < 92) return REQ_SIZE;
      if (r < 97) return REQ_NOP;
      return REQ_CLEAR;
   endfunction

   // present one request and hold it until it is taken
   task automatic send(input logic [2:0] kind, input logic [31:0] data);
      int gap;
      gap = draw_wait();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_request(kind, data);
   endtask

   // hold off requests until every response is back
   task automatic quiesce();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending() > 0) @(posedge clock);
   endtask

   task automatic mixed_run(input int count);
      repeat (count) begin
         if ($urandom_range(0, 29) == 0) steady = ~steady;
         send(pick_kind(), rand_key());
      end
      steady = 1'b0;
   endtask

   // response side: random back-pressure per response
   initial begin : rsp_side
      int stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = draw_wait();
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   // response monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         sb.check_response(rsp_tuser, rsp_tdata[31:0], rsp_tdata[42:32]);
   end

   // stimulus
   initial begin
      sb = new(HEAP_DEPTH);
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // empty queue: size answers zero, and every extract or peek answers the empty error
      send(REQ_SIZE, 32'h0);
      send(REQ_PEEK_MIN, 32'h0);
      send(REQ_PEEK_MAX, 32'hffff_ffff);
      send(REQ_EXTRACT_MIN, 32'h0);
      send(REQ_EXTRACT_MAX, 32'h0);
      // one entry: min and max are the same key
      send(REQ_INSERT, 32'h0000_0005);
      send(REQ_PEEK_MAX, 32'h0);
      send(REQ_EXTRACT_MAX, 32'h0);
      // two entries, then the key extremes and duplicates
      send(REQ_INSERT, 32'h7fff_ffff);
      send(REQ_INSERT, 32'h8000_0000);
      send(REQ_PEEK_MAX, 32'h0);
      send(REQ_PEEK_MIN, 32'h0);
      send(REQ_INSERT, 32'h0);
      send(REQ_INSERT, 32'hffff_ffff);
      send(REQ_INSERT, 32'h8000_0000);
      send(REQ_NOP, 32'h1234_5678);
      send(REQ_SIZE, 32'hffff_ffff);
      send(REQ_EXTRACT_MAX, 32'h0);
      send(REQ_EXTRACT_MIN, 32'h0);
      send(REQ_EXTRACT_MIN, 32'h0);
      send(REQ_EXTRACT_MAX, 32'h0);
      // clear with entries held, then empty again
      send(REQ_CLEAR, 32'hffff_ffff);
      send(REQ_EXTRACT_MIN, 32'h0);
      send(REQ_PEEK_MAX, 32'h0);
      quiesce();

      mixed_run(30);
      quiesce();

      // fill to capacity, with a few peeks along the way
      steady = 1'b1;
      while (sb.fill() < HEAP_DEPTH) begin
         if ($urandom_range(0, 39) == 0) begin
            steady = ~steady;
            send($urandom_range(0, 1) ? REQ_PEEK_MIN : REQ_PEEK_MAX, rand_key());
         end else begin
            send(REQ_INSERT, rand_key());
         end
      end
      steady = 1'b0;
      // inserts into the full queue are dropped
      repeat (6) send(REQ_INSERT, rand_key());
      send(REQ_SIZE, 32'h0);
      // deep extracts, refilling now and then
      repeat (30) begin
         case ($urandom_range(0, 4))
            0, 1: send(REQ_EXTRACT_MIN, rand_key());
            2, 3: send(REQ_EXTRACT_MAX, rand_key());
            default: send(REQ_INSERT, rand_key());
         endcase
      end
      quiesce();
      send(REQ_CLEAR, 32'h0);

      mixed_run(30);
      quiesce();
      repeat (10) @(posedge clock);

      $display("run covered %0d requests and %0d responses, peak fill %0d of %0d",
               sb.requests, sb.responses, sb.peak, HEAP_DEPTH);
      $display("dropped inserts on a full queue: %0d, empty-queue errors: %0d",
               sb.full_drops, sb.empty_hits);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end
endmodule

>>> sim.f
src/mmhq_pkg.sv
src/mmhq_cell.sv
src/mmhq_chain.sv
src/min_max_heap_queue.sv
tb/tb.sv
